### hdl/ssf_pkg.sv
// Shared types and constants for the sample smoothing filter.
// No dependencies.
`timescale 1ns / 1ps
package ssf_pkg;
    localparam int MAX_WINDOW_DEF  = 63;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int SW = SAMPLE_BITS_DEF;
    localparam logic [1:0] MODE_PASS = 2'd0;
    localparam logic [1:0] MODE_MAVG = 2'd1;
    localparam logic [1:0] MODE_EMA  = 2'd2;
    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_WINDOW = 1'b1;

    typedef struct packed {
        logic signed [SW-1:0] temperature;
        logic signed [SW-1:0] precip_rate;
        logic signed [SW-1:0] wind_speed;
        logic                 last_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [SW-1:0] smooth_temperature;
        logic signed [SW-1:0] smooth_precip_rate;
        logic signed [SW-1:0] smooth_wind_speed;
        logic                 last_result;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_WEIGHT, ST_EMA, ST_PLAN, ST_RDADDR, ST_ACC, ST_DIV, ST_EMIT
    } state_t;
endpackage

### hdl/ssf_ram.sv
// Generic single-port-write, registered-read RAM.
// No dependencies.
`timescale 1ns / 1ps
module ssf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### hdl/ssf_div.sv
// Serial signed divider (restoring, one quotient bit per cycle), truncating.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module ssf_div #(
    parameter int NW = 32,
    parameter int DW = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [NW-1:0] num,
    input  logic [DW-1:0]        den,
    output logic                 done,
    output logic signed [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW-1:0] d_reg, d_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [DW:0]   trial;

    always_comb begin
        q_next = q_reg; r_next = r_reg; d_next = d_reg; neg_next = neg_reg;
        cnt_next = cnt_reg; busy_next = busy_reg;
        done = busy_reg && (cnt_reg == '0);
        trial = {r_reg[DW-1:0], q_reg[NW-1]};
        if (start) begin
            q_next = num[NW-1] ? (~num + 1'b1) : num;
            neg_next = num[NW-1];
            r_next = '0; d_next = den; cnt_next = CW'(NW); busy_next = 1'b1;
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                if (trial >= {1'b0, d_reg}) begin
                    r_next = trial - {1'b0, d_reg};
                    q_next = {q_reg[NW-2:0], 1'b1};
                end else begin
                    r_next = trial;
                    q_next = {q_reg[NW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end
    assign quo = neg_reg ? $signed(~q_reg + 1'b1) : $signed(q_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0; cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next; cnt_reg <= cnt_next;
        end
        q_reg <= q_next; r_reg <= r_next; d_reg <= d_next; neg_reg <= neg_next;
    end
endmodule

### hdl/sample_smoothing_filter_unit.sv
// Top level of the sample smoothing filter.
// Depends on ssf_pkg, ssf_ram and ssf_div.
`timescale 1ns / 1ps
// Three signed channels are smoothed per sample: mode 0 (and 3) passes
// through, mode 1 is a centred moving average of half width window/2 with
// windows clipped at series ends and truncating division by the true count,
// mode 2 is an exponential average with alpha = floor(131072/(window+1)).
// One sample is taken at a time; s_ready is low while it is processed.
// Pass through stores the sample and then offers it for the output transfer.
// Exponential mode multiplies, then updates, each channel in turn through one
// shared 17x25 multiplier. A moving average result takes one ring read per
// window sample, then its three sums go in turn through the one shared serial
// divider; on the last sample up to half width + 1 results are flushed, oldest
// first. A window write recomputes alpha with the same divider, before the
// next sample is taken.
// Ring memories need no clearing.
module sample_smoothing_filter_unit #(
    parameter int MAX_WINDOW  = ssf_pkg::MAX_WINDOW_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ssf_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ssf_pkg::out_item_t  m_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [5:0]          cfg_wdata
);
    localparam int SW   = ssf_pkg::SW;
    localparam int AW   = 6;                 // ring index, 64 slots
    localparam int SUMW = SW + 8;             // sum of up to 63 samples
    localparam int WEIGHT_ONE2 = 131072;

    // Configuration
    logic [1:0] mode_reg;
    logic [5:0] window_reg;
    logic [16:0] weight_reg, weight_next;
    logic        wpend_reg, wpend_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= ssf_pkg::MODE_PASS;
            window_reg <= 6'd30;
        end else if (cfg_we) begin
            if (cfg_index == ssf_pkg::REG_MODE) begin
                mode_reg <= cfg_wdata[1:0];
            end else begin
                window_reg <= cfg_wdata;
            end
        end
    end

    // Effective window and half width
    logic [5:0] eff_win;
    logic [5:0] half;
    always_comb begin
        eff_win = (window_reg == 6'd0) ? 6'd1 : window_reg;
        if (32'(eff_win) > MAX_WINDOW) begin
            eff_win = 6'(MAX_WINDOW);
        end
        half = {1'b0, eff_win[5:1]};
    end

    ssf_pkg::state_t state_reg, state_next;
    ssf_pkg::in_item_t in_reg, in_next;
    ssf_pkg::out_item_t out_reg, out_next;
    logic           oval_reg, oval_next;
    logic [AW-1:0]  slot_reg, slot_next, cur_reg, cur_next;
    logic [6:0]     cnt_reg, cnt_next, c_reg, c_next;
    logic [6:0]     d_reg, d_next, lo_reg, lo_next, hi_reg, hi_next;
    logic [6:0]     k_reg, k_next;
    logic           kval_reg, kval_next;
    logic           flush_reg, flush_next;
    logic [1:0]     ch_reg, ch_next;
    logic signed [SUMW-1:0] sum_reg [3];
    logic signed [SUMW-1:0] sum_next [3];
    logic signed [SW-1:0]   prev_reg [3];
    logic signed [SW-1:0]   prev_next [3];
    logic signed [SW+17:0]  prod_reg, prod_next;
    logic           mulv_reg, mulv_next;

    // Ring memories
    logic           ring_we;
    logic [AW-1:0]  raddr;
    logic [SW-1:0]  rd_t, rd_p, rd_w;
    ssf_ram #(.WIDTH(SW), .DEPTH(64)) u_ring_t (.aclk(aclk), .we(ring_we),
        .waddr(slot_reg), .wdata(in_reg.temperature), .raddr(raddr), .rdata(rd_t));
    ssf_ram #(.WIDTH(SW), .DEPTH(64)) u_ring_p (.aclk(aclk), .we(ring_we),
        .waddr(slot_reg), .wdata(in_reg.precip_rate), .raddr(raddr), .rdata(rd_p));
    ssf_ram #(.WIDTH(SW), .DEPTH(64)) u_ring_w (.aclk(aclk), .we(ring_we),
        .waddr(slot_reg), .wdata(in_reg.wind_speed), .raddr(raddr), .rdata(rd_w));

    // Shared divider: window sums and the alpha computation
    logic                   div_start, div_done;
    logic signed [SUMW-1:0] div_num, div_quo;
    logic [7:0]             div_den;
    ssf_div #(.NW(SUMW), .DW(8)) u_div (.aclk(aclk), .aresetn(aresetn),
        .start(div_start), .num(div_num), .den(div_den), .done(div_done),
        .quo(div_quo));

    // Current channel sample and previous average, by channel counter
    logic signed [SW-1:0] x_ch, p_ch;
    logic signed [SW:0]   diff;
    logic signed [SW+17:0] fl;
    always_comb begin
        case (ch_reg)
            2'd0:    x_ch = in_reg.temperature;
            2'd1:    x_ch = in_reg.precip_rate;
            default: x_ch = in_reg.wind_speed;
        endcase
        case (ch_reg)
            2'd0:    p_ch = prev_reg[0];
            2'd1:    p_ch = prev_reg[1];
            default: p_ch = prev_reg[2];
        endcase
        diff = $signed({x_ch[SW-1], x_ch}) - $signed({p_ch[SW-1], p_ch});
        fl = prod_reg >>> 16;                 // arithmetic shift is floor
    end

    logic [6:0] top_c, hi_c;
    always_comb begin
        top_c = (c_reg < {1'b0, half}) ? c_reg : {1'b0, half};
        hi_c  = (7'({half, 1'b0}) < c_reg) ? 7'({half, 1'b0}) : c_reg;
    end

    always_comb begin
        state_next = state_reg; in_next = in_reg; out_next = out_reg;
        oval_next = oval_reg; slot_next = slot_reg; cur_next = cur_reg;
        cnt_next = cnt_reg; c_next = c_reg; d_next = d_reg; lo_next = lo_reg;
        hi_next = hi_reg; k_next = k_reg; kval_next = kval_reg;
        flush_next = flush_reg; ch_next = ch_reg; prod_next = prod_reg;
        mulv_next = mulv_reg; weight_next = weight_reg; wpend_next = wpend_reg;
        for (int j = 0; j < 3; j++) begin
            sum_next[j] = sum_reg[j];
            prev_next[j] = prev_reg[j];
        end
        ring_we = 1'b0; raddr = cur_reg - k_reg[AW-1:0];
        div_start = 1'b0; div_num = '0; div_den = '0;
        s_ready = 1'b0;

        if (oval_reg && m_ready) begin
            oval_next = 1'b0;
        end
        if (cfg_we && cfg_index == ssf_pkg::REG_WINDOW) begin
            wpend_next = 1'b1;
        end

        case (state_reg)
            ssf_pkg::ST_IDLE: begin
                if (wpend_reg) begin
                    // recompute alpha = 2*65536/(window+1)
                    div_start = 1'b1;
                    div_num = SUMW'(WEIGHT_ONE2);
                    div_den = {2'b0, eff_win} + 8'd1;
                    wpend_next = 1'b0;
                    state_next = ssf_pkg::ST_WEIGHT;
                end else begin
                    s_ready = !oval_reg;
                    if (s_valid && !oval_reg) begin
                        in_next = s_data;
                        state_next = ssf_pkg::ST_PLAN;
                    end
                end
            end
            ssf_pkg::ST_WEIGHT: begin
                if (div_done) begin
                    weight_next = div_quo[16:0];
                    state_next = ssf_pkg::ST_IDLE;
                end
            end
            ssf_pkg::ST_PLAN: begin
                // store sample, advance the slot and the series count
                ring_we = 1'b1;
                cur_next = slot_reg;
                slot_next = slot_reg + 1'b1;
                c_next = cnt_reg;
                if (in_reg.last_sample) begin
                    cnt_next = '0;
                end else if (cnt_reg != 7'd127) begin
                    cnt_next = cnt_reg + 1'b1;
                end
                ch_next = 2'd0; mulv_next = 1'b0;
                if (mode_reg == ssf_pkg::MODE_MAVG) begin
                    flush_next = in_reg.last_sample;
                    state_next = ssf_pkg::ST_RDADDR;
                    // d chosen in ST_RDADDR via flush flag; mark d as "top"
                    d_next = 7'h7f;
                end else if (mode_reg == ssf_pkg::MODE_EMA) begin
                    state_next = ssf_pkg::ST_EMA;
                end else begin
                    out_next = {in_reg.temperature, in_reg.precip_rate,
                                in_reg.wind_speed, in_reg.last_sample};
                    state_next = ssf_pkg::ST_EMIT;
                end
            end
            ssf_pkg::ST_EMA: begin
                if (!mulv_reg) begin
                    prod_next = (SW+18)'(diff) * (SW+18)'($signed({1'b0, weight_reg}));
                    mulv_next = 1'b1;
                end else begin
                    mulv_next = 1'b0;
                    if (c_reg == '0) begin
                        prev_next[ch_reg] = x_ch;
                    end else begin
                        prev_next[ch_reg] = p_ch + fl[SW-1:0];
                    end
                    if (ch_reg == 2'd2) begin
                        out_next.smooth_temperature = prev_next[0];
                        out_next.smooth_precip_rate = prev_next[1];
                        out_next.smooth_wind_speed  = prev_next[2];
                        out_next.last_result = in_reg.last_sample;
                        state_next = ssf_pkg::ST_EMIT;
                    end
                    ch_next = ch_reg + 1'b1;
                end
            end
            ssf_pkg::ST_RDADDR: begin
                // pick the next window, or finish
                if (d_reg == 7'h7f) begin
                    if (flush_reg) begin
                        d_next = top_c;
                        lo_next = (top_c > {1'b0, half}) ? top_c - {1'b0, half} : '0;
                        hi_next = (top_c + {1'b0, half} < c_reg) ?
                                  top_c + {1'b0, half} : c_reg;
                    end else if (c_reg >= {1'b0, half}) begin
                        d_next = '0; lo_next = '0; hi_next = hi_c;
                    end else begin
                        state_next = ssf_pkg::ST_IDLE;
                    end
                    if (flush_reg || c_reg >= {1'b0, half}) begin
                        k_next = (flush_reg && top_c > {1'b0, half}) ?
                                 top_c - {1'b0, half} : '0;
                        kval_next = 1'b0;
                        for (int j = 0; j < 3; j++) sum_next[j] = '0;
                        state_next = ssf_pkg::ST_ACC;
                    end
                end
            end
            ssf_pkg::ST_ACC: begin
                // one ring read per cycle; data arrives in the next cycle
                if (kval_reg) begin
                    sum_next[0] = sum_reg[0] + SUMW'($signed(rd_t));
                    sum_next[1] = sum_reg[1] + SUMW'($signed(rd_p));
                    sum_next[2] = sum_reg[2] + SUMW'($signed(rd_w));
                end
                if (k_reg <= hi_reg) begin
                    kval_next = 1'b1;
                    k_next = k_reg + 1'b1;
                end else begin
                    kval_next = 1'b0;
                    if (kval_reg) begin
                        ch_next = 2'd0;
                        div_start = 1'b1;
                        div_num = sum_next[0];
                        div_den = 8'(hi_reg - lo_reg + 7'd1);
                        state_next = ssf_pkg::ST_DIV;
                    end
                end
            end
            ssf_pkg::ST_DIV: begin
                // keep each quotient in its sum slot; a held result stays untouched
                if (div_done) begin
                    case (ch_reg)
                        2'd0:    sum_next[0] = div_quo;
                        2'd1:    sum_next[1] = div_quo;
                        default: sum_next[2] = div_quo;
                    endcase
                    if (ch_reg == 2'd2) begin
                        state_next = ssf_pkg::ST_EMIT;
                    end else begin
                        ch_next = ch_reg + 1'b1;
                        div_start = 1'b1;
                        div_num = (ch_reg == 2'd0) ? sum_reg[1] : sum_reg[2];
                        div_den = 8'(hi_reg - lo_reg + 7'd1);
                    end
                end
            end
            ssf_pkg::ST_EMIT: begin
                if (!oval_reg) begin
                    oval_next = 1'b1;
                    if (mode_reg == ssf_pkg::MODE_MAVG) begin
                        out_next.smooth_temperature = sum_reg[0][SW-1:0];
                        out_next.smooth_precip_rate = sum_reg[1][SW-1:0];
                        out_next.smooth_wind_speed  = sum_reg[2][SW-1:0];
                        out_next.last_result = flush_reg && (d_reg == '0);
                    end
                    if (mode_reg == ssf_pkg::MODE_MAVG && flush_reg && d_reg != '0) begin
                        d_next = d_reg - 1'b1;
                        lo_next = (d_reg - 1'b1 > {1'b0, half}) ?
                                  d_reg - 1'b1 - {1'b0, half} : '0;
                        hi_next = (d_reg - 1'b1 + {1'b0, half} < c_reg) ?
                                  d_reg - 1'b1 + {1'b0, half} : c_reg;
                        k_next = (d_reg - 1'b1 > {1'b0, half}) ?
                                 d_reg - 1'b1 - {1'b0, half} : '0;
                        kval_next = 1'b0;
                        for (int j = 0; j < 3; j++) sum_next[j] = '0;
                        state_next = ssf_pkg::ST_ACC;
                    end else begin
                        state_next = ssf_pkg::ST_IDLE;
                    end
                end
            end
            default: state_next = ssf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ssf_pkg::ST_IDLE;
            oval_reg <= 1'b0;
            slot_reg <= '0;
            cnt_reg <= '0;
            weight_reg <= 17'd4228;
            wpend_reg <= 1'b0;
            for (int j = 0; j < 3; j++) prev_reg[j] <= '0;
        end else begin
            state_reg <= state_next;
            oval_reg <= oval_next;
            slot_reg <= slot_next;
            cnt_reg <= cnt_next;
            weight_reg <= weight_next;
            wpend_reg <= wpend_next;
            for (int j = 0; j < 3; j++) prev_reg[j] <= prev_next[j];
        end
        in_reg <= in_next; out_reg <= out_next; cur_reg <= cur_next;
        c_reg <= c_next; d_reg <= d_next; lo_reg <= lo_next; hi_reg <= hi_next;
        k_reg <= k_next; kval_reg <= kval_next; flush_reg <= flush_next;
        ch_reg <= ch_next; prod_reg <= prod_next; mulv_reg <= mulv_next;
        for (int j = 0; j < 3; j++) sum_reg[j] <= sum_next[j];
    end

    assign m_valid = oval_reg;
    assign m_data  = out_reg;

    // No new sample transfer while a result still waits
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> !m_valid) else $error("accept while result pending");
    // The write slot advances by one per stored sample only
    a_slot_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ssf_pkg::ST_PLAN) |=> $stable(slot_reg)) else $error("slot moved");
    // A held result does not change until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_data)) else $error("result changed");
endmodule

### verif/testbench.sv
// Self-checking testbench for sample_smoothing_filter_unit.
// Depends on ssf_pkg and the filter RTL; drives valid/ready traffic both ways.
`timescale 1ns / 1ps
module testbench;

    localparam int SAMPLE_MAX  = 8388607;
    localparam int SAMPLE_MIN  = -8388608;
    localparam int IDLE_CYCLES = 400;       // covers a mid-series average with no result
    localparam int CYCLE_LIMIT = 20000000;
    localparam int RANDOM_ITEMS = 300;

    typedef enum logic { ROW_CFG, ROW_ITEM } row_kind_t;

    typedef struct {
        row_kind_t           kind;
        logic                reg_index;
        logic [5:0]          reg_value;
        ssf_pkg::in_item_t   sample;
        bit                  typed;      // expected result given in the row
        ssf_pkg::out_item_t  result;
    } stim_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    ssf_pkg::in_item_t   s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    ssf_pkg::out_item_t  m_data;
    logic                cfg_we = 1'b0;
    logic                cfg_index = ssf_pkg::REG_MODE;
    logic [5:0]          cfg_wdata = '0;

    // Filter state mirrored by the predictor
    logic [1:0] flt_mode;
    logic [5:0] flt_window;
    int         flt_weight;
    int         sample_ring [3][64];
    int         samples_seen;
    int         ring_slot;
    int         ema_prev [3];

    ssf_pkg::out_item_t  expected_q[$];
    int         mismatches = 0;
    int         items_sent = 0;
    int         results_seen = 0;
    int         cycle_count = 0;
    stim_row_t  rows[$];

    sample_smoothing_filter_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int eff_window(logic [5:0] w);
        if (w == 0) return 1;
        if (w > 63) return 63;
        return w;
    endfunction

    function automatic ssf_pkg::out_item_t pack_result(int v0, int v1, int v2, bit last);
        ssf_pkg::out_item_t r;
        r.smooth_temperature = v0[23:0];
        r.smooth_precip_rate = v1[23:0];
        r.smooth_wind_speed  = v2[23:0];
        r.last_result        = last;
        return r;
    endfunction

    // Mean over ring offsets lo..hi back from slot cur, truncating toward zero
    function automatic ssf_pkg::out_item_t window_mean(int cur, int lo, int hi, bit last);
        longint sum [3];
        int     mean [3];
        int     slot;
        sum = '{0, 0, 0};
        for (int k = lo; k <= hi; k++) begin
            slot = (cur - k) & 63;
            for (int j = 0; j < 3; j++) sum[j] += sample_ring[j][slot];
        end
        for (int j = 0; j < 3; j++) mean[j] = int'(sum[j] / longint'(hi - lo + 1));
        return pack_result(mean[0], mean[1], mean[2], last);
    endfunction

    function automatic void apply_reg(logic idx, logic [5:0] value);
        if (idx == ssf_pkg::REG_MODE) begin
            flt_mode = value[1:0];
        end else begin
            flt_window = value;
            flt_weight = 131072 / (eff_window(value) + 1);
        end
    endfunction

    // Work out the results one accepted sample causes and advance the state
    task automatic smooth_predict(input ssf_pkg::in_item_t it,
                                  ref ssf_pkg::out_item_t res[$]);
        int     x [3];
        int     y [3];
        int     cur, c, h, top, lo, hi;
        longint diff;
        bit     last;
        x[0] = it.temperature;
        x[1] = it.precip_rate;
        x[2] = it.wind_speed;
        last = it.last_sample;
        cur  = ring_slot;
        c    = samples_seen;
        h    = eff_window(flt_window) / 2;
        for (int j = 0; j < 3; j++) sample_ring[j][cur] = x[j];
        ring_slot = (cur + 1) & 63;

        if (flt_mode == ssf_pkg::MODE_MAVG) begin
            if (last) begin
                // flush every unanswered sample, oldest first
                top = (c < h) ? c : h;
                for (int d = top; d >= 0; d--) begin
                    lo = (d > h) ? d - h : 0;
                    hi = (d + h < c) ? d + h : c;
                    res.push_back(window_mean(cur, lo, hi, d == 0));
                end
            end else if (c >= h) begin
                hi = (2 * h < c) ? 2 * h : c;
                res.push_back(window_mean(cur, 0, hi, 1'b0));
            end
        end else if (flt_mode == ssf_pkg::MODE_EMA) begin
            for (int j = 0; j < 3; j++) begin
                if (c == 0) begin
                    y[j] = x[j];    // seed the average with the first sample
                end else begin
                    diff = longint'(x[j]) - longint'(ema_prev[j]);
                    y[j] = int'(longint'(ema_prev[j]) + ((diff * longint'(flt_weight)) >>> 16));
                end
                ema_prev[j] = y[j];
            end
            res.push_back(pack_result(y[0], y[1], y[2], last));
        end else begin
            res.push_back(pack_result(x[0], x[1], x[2], last));
        end

        if (last) samples_seen = 0;
        else if (c < 127) samples_seen = c + 1;
    endtask

    // Result side: check each transfer, then pick the next stall
    int stall_phase = 0;
    always @(posedge aclk) begin
        ssf_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result %h at cycle %0d", m_data, cycle_count);
            end else begin
                want = expected_q.pop_front();
                if (m_data.smooth_temperature !== want.smooth_temperature ||
                    m_data.smooth_precip_rate !== want.smooth_precip_rate ||
                    m_data.smooth_wind_speed  !== want.smooth_wind_speed  ||
                    m_data.last_result        !== want.last_result) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch at cycle %0d: expected %0d %0d %0d %b got %0d %0d %0d %b",
                                 cycle_count, want.smooth_temperature,
                                 want.smooth_precip_rate, want.smooth_wind_speed,
                                 want.last_result, m_data.smooth_temperature,
                                 m_data.smooth_precip_rate, m_data.smooth_wind_speed,
                                 m_data.last_result);
                end
            end
        end
        // stall pattern: long ready stretches, then bursts of random stalls
        stall_phase = (stall_phase + 1) % 97;
        if (stall_phase < 40) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 2) != 0);
    end

    function automatic int rand_sample();
        case ($urandom_range(0, 5))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return $urandom_range(0, 2047) - 1024;
            default: return int'({{8{1'b0}}, 24'($urandom)}) - (1 << 23);
        endcase
    endfunction

    function automatic ssf_pkg::in_item_t make_sample(int t, int p, int w, bit last);
        ssf_pkg::in_item_t it;
        it.temperature = t[23:0];
        it.precip_rate = p[23:0];
        it.wind_speed  = w[23:0];
        it.last_sample = last;
        return it;
    endfunction

    function automatic void add_cfg(logic idx, logic [5:0] value);
        stim_row_t r;
        r = '{ROW_CFG, idx, value, '0, 1'b0, '0};
        rows.push_back(r);
    endfunction

    function automatic void add_item(ssf_pkg::in_item_t it, bit typed,
                                     ssf_pkg::out_item_t want);
        stim_row_t r;
        r = '{ROW_ITEM, ssf_pkg::REG_MODE, '0, it, typed, want};
        rows.push_back(r);
    endfunction

    // Hold off until every expected result is out and the block has settled
    task automatic wait_drained();
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (IDLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [5:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        apply_reg(idx, value);
        cfg_we <= 1'b0;
    endtask

    int burst_left = 0;

    // Hold valid and payload until the transfer, then maybe drop into a gap
    task automatic send_sample(ssf_pkg::in_item_t it, bit typed,
                               ssf_pkg::out_item_t want);
        ssf_pkg::out_item_t res[$];
        int gap;
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!(s_valid && s_ready));
        smooth_predict(it, res);
        if (typed) expected_q.push_back(want);
        else foreach (res[i]) expected_q.push_back(res[i]);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 8);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    initial begin
        ssf_pkg::in_item_t it;
        logic [5:0] win;
        int         series_len;
        int         phases;
        bit         close_series;

        flt_mode     = ssf_pkg::MODE_PASS;
        flt_window   = 6'd30;
        flt_weight   = 131072 / 31;
        samples_seen = 0;
        ring_slot    = 0;
        ema_prev     = '{0, 0, 0};

        // Directed rows: extremes, every mode, clipped and degenerate windows
        it = make_sample(SAMPLE_MAX, SAMPLE_MIN, 0, 1'b0);
        add_item(it, 1'b1, pack_result(SAMPLE_MAX, SAMPLE_MIN, 0, 1'b0));
        it = make_sample(SAMPLE_MIN, SAMPLE_MAX, -1, 1'b1);
        add_item(it, 1'b1, pack_result(SAMPLE_MIN, SAMPLE_MAX, -1, 1'b1));
        add_cfg(ssf_pkg::REG_MODE, 6'b111111);       // mode three passes through
        it = make_sample(1, -1, SAMPLE_MAX, 1'b1);
        add_item(it, 1'b1, pack_result(1, -1, SAMPLE_MAX, 1'b1));
        add_cfg(ssf_pkg::REG_MODE, {4'b0, ssf_pkg::MODE_EMA});
        add_cfg(ssf_pkg::REG_WINDOW, 6'd1);
        it = make_sample(-5, 1000, SAMPLE_MIN, 1'b0);
        add_item(it, 1'b1, pack_result(-5, 1000, SAMPLE_MIN, 1'b0));
        add_item(make_sample(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 1'b0), 1'b0, '0);
        add_item(make_sample(SAMPLE_MIN, 7, -3, 1'b1), 1'b0, '0);
        add_cfg(ssf_pkg::REG_WINDOW, 6'd63);
        add_item(make_sample(SAMPLE_MIN, SAMPLE_MAX, 12, 1'b0), 1'b0, '0);
        add_item(make_sample(SAMPLE_MAX, SAMPLE_MIN, -12, 1'b0), 1'b0, '0);
        add_item(make_sample(-1, 1, 0, 1'b1), 1'b0, '0);
        add_cfg(ssf_pkg::REG_MODE, {4'b0, ssf_pkg::MODE_MAVG});
        add_cfg(ssf_pkg::REG_WINDOW, 6'd0);          // zero window acts as one
        it = make_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b0);
        add_item(it, 1'b1, pack_result(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b0));
        it = make_sample(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 1'b1);
        add_item(it, 1'b1, pack_result(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 1'b1));
        add_cfg(ssf_pkg::REG_WINDOW, 6'd4);
        add_item(make_sample(SAMPLE_MAX, SAMPLE_MIN, 3, 1'b0), 1'b0, '0);
        add_item(make_sample(SAMPLE_MAX, SAMPLE_MIN, -3, 1'b0), 1'b0, '0);
        add_item(make_sample(SAMPLE_MIN, SAMPLE_MAX, 5, 1'b0), 1'b0, '0);
        add_item(make_sample(-7, 7, SAMPLE_MAX, 1'b0), 1'b0, '0);
        add_item(make_sample(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 1'b1), 1'b0, '0);
        add_cfg(ssf_pkg::REG_WINDOW, 6'd63);
        add_item(make_sample(100, -100, SAMPLE_MAX, 1'b1), 1'b0, '0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                s_valid <= 1'b0;
                write_reg(rows[i].reg_index, rows[i].reg_value);
            end else begin
                send_sample(rows[i].sample, rows[i].typed, rows[i].result);
            end
        end

        // Random phases: new mode and window, then series of random samples
        phases = 0;
        while (items_sent < rows.size() + RANDOM_ITEMS) begin
            s_valid <= 1'b0;
            write_reg(ssf_pkg::REG_MODE, 6'($urandom));
            case ($urandom_range(0, 7))
                0: win = 6'd0;
                1: win = 6'd63;
                2: win = 6'($urandom);
                default: win = 6'($urandom_range(1, 10));
            endcase
            write_reg(ssf_pkg::REG_WINDOW, win);
            phases++;
            repeat ($urandom_range(1, 3)) begin
                series_len = $urandom_range(1, (win > 20) ? 40 : 14);
                // now and then leave the series open across the next setting
                close_series = ($urandom_range(0, 4) != 0);
                for (int n = 0; n < series_len; n++) begin
                    it = make_sample(rand_sample(), rand_sample(), rand_sample(),
                                     close_series && (n == series_len - 1));
                    send_sample(it, 1'b0, '0);
                end
            end
            if (phases == 4) begin
                // pause the sender until the block has answered everything
                s_valid <= 1'b0;
                while (expected_q.size() != 0) @(posedge aclk);
            end
        end
        s_valid <= 1'b0;

        wait_drained();
        $display("Sent %0d samples over %0d random settings, checked %0d results",
                 items_sent, phases, results_seen);
        $display("Covered pass-through, mode three, EMA and centred average with flushes");
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
